FILE: rtl/itlc_pkg.sv
// shared constants, types and state codes of the inclusive two-level cache model
package itlc_pkg;

   // geometry
   localparam int ADDR_W      = 64;
   localparam int NUM_CORES   = 4;
   localparam int CORE_W      = 2;
   localparam int L1_SETS     = 32;
   localparam int L1_WAYS     = 8;
   localparam int L2_SETS     = 2048;
   localparam int L2_WAYS     = 16;
   localparam int BLOCK_BYTES = 64;
   localparam int STAMP_W     = 64;

   // derived widths
   localparam int OFS_W    = $clog2(BLOCK_BYTES);
   localparam int BLK_W    = ADDR_W - OFS_W;
   localparam int L1_SET_W = $clog2(L1_SETS);
   localparam int L2_SET_W = $clog2(L2_SETS);
   localparam int L1_TAG_W = BLK_W - L1_SET_W;
   localparam int L2_TAG_W = BLK_W - L2_SET_W;
   localparam int L1_WAY_W = $clog2(L1_WAYS);
   localparam int L2_WAY_W = $clog2(L2_WAYS);
   localparam int L1_ROW_W = CORE_W + L1_SET_W;
   localparam int L2_ROW_W = CORE_W + L2_SET_W;
   localparam int L1_ROWS  = NUM_CORES * L1_SETS;
   localparam int L2_ROWS  = NUM_CORES * L2_SETS;

   // decoded access as it sits in the queue
   typedef struct packed {
      logic                insn;
      logic [CORE_W-1:0]   core;
      logic [L1_SET_W-1:0] l1_set;
      logic [L1_TAG_W-1:0] l1_tag;
      logic [L2_SET_W-1:0] l2_set;
      logic [L2_TAG_W-1:0] l2_tag;
      logic                user;
   } item_type;

   // one L1 set: set clock, valid bits, stamps and tags of all ways
   typedef struct packed {
      logic [STAMP_W-1:0]                clk;
      logic [L1_WAYS-1:0]                vld;
      logic [L1_WAYS-1:0][STAMP_W-1:0]   stamp;
      logic [L1_WAYS-1:0][L1_TAG_W-1:0]  tag;
   } l1_row_type;

   // one L2 set
   typedef struct packed {
      logic [STAMP_W-1:0]                clk;
      logic [L2_WAYS-1:0]                vld;
      logic [L2_WAYS-1:0][STAMP_W-1:0]   stamp;
      logic [L2_WAYS-1:0][L2_TAG_W-1:0]  tag;
   } l2_row_type;

   // result beat
   typedef struct packed {
      logic              l1_hit;
      logic              l2_probed;
      logic              l2_hit;
      logic              victim_valid;
      logic [ADDR_W-1:0] victim_address;
      logic              data_l1_invalidated;
      logic              insn_l1_invalidated;
      logic              was_user;
   } result_type;

   // queue handshake between front and back
   typedef struct packed {
      logic valid;
      logic hold;
   } queue_ctl_type;

   // back-end sequencer states
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_L1_LOOK,
      S_L1_MIN,
      S_L1_WR,
      S_L2_LOOK,
      S_L2_MIN,
      S_L2_WR,
      S_INV_RD,
      S_INV_D,
      S_INV_I,
      S_DONE
   } state_type;

endpackage

FILE: rtl/itlc_front.sv
// front end: decodes accesses into set and tag fields and queues them
module itlc_front import itlc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [1:0]        req_core,
   input  logic [ADDR_W-1:0] req_address,
   input  logic              req_user_mode,
   output queue_ctl_type     q_ctl,
   input  logic              q_hold,
   input  logic              q_pop,
   output item_type          q_item
);

   item_type   dec;
   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // split the address into block fields for both levels
   always_comb begin
      dec.insn   = req_action;
      dec.core   = req_core;
      dec.l1_set = req_address[OFS_W +: L1_SET_W];
      dec.l1_tag = req_address[ADDR_W-1 -: L1_TAG_W];
      dec.l2_set = req_address[OFS_W +: L2_SET_W];
      dec.l2_tag = req_address[ADDR_W-1 -: L2_TAG_W];
      dec.user   = req_user_mode;
   end

   // two-entry queue toward the back end
   assign req_ready   = !q_hold && (count_ff != 2'd2);
   assign push        = req_valid && req_ready;
   assign q_ctl.valid = (count_ff != 2'd0);
   assign q_ctl.hold  = q_hold;
   assign pop         = q_pop && q_ctl.valid;
   assign q_item      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

FILE: rtl/itlc_back.sv
// back end: tag arrays and the sequencer for lookup, fill and back-invalidation
module itlc_back import itlc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  queue_ctl_type q_ctl,
   input  item_type      q_item,
   output logic          q_pop,
   output logic          q_hold,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output result_type    rsp_data
);

   // set arrays
   l1_row_type l1d_mem [L1_ROWS];
   l1_row_type l1i_mem [L1_ROWS];
   l2_row_type l2_mem  [L2_ROWS];
   l1_row_type l1d_q, l1i_q;
   l2_row_type l2_q;

   logic [L1_ROW_W-1:0] l1_raddr, l1_waddr;
   logic [L2_ROW_W-1:0] l2_raddr, l2_waddr;
   logic                l1d_we, l1i_we, l2_we;
   l1_row_type          l1_wdata;
   l2_row_type          l2_wdata;

   state_type           state_ff, state_in;
   item_type            item_ff, item_in;
   result_type          res_ff, res_in;
   result_type          rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   l1_row_type          l1_row_ff, l1_row_in;
   l2_row_type          l2_row_ff, l2_row_in;
   logic [L2_WAY_W-1:0] pick_ff, pick_in;
   logic [L2_WAY_W-1:0] iter_ff, iter_in;
   logic [L2_TAG_W-1:0] vtag_ff, vtag_in;
   logic [L2_ROW_W-1:0] clr_ff, clr_in;

   logic [BLK_W-1:0]    vblk;
   logic [L1_ROW_W-1:0] inv_row;
   l1_row_type          l1_rd;
   logic [L1_TAG_W-1:0] l1_cmp_tag;
   logic                l1_hit, l1_free;
   logic [L1_WAY_W-1:0] l1_hit_way, l1_free_way;
   logic                l2_hit, l2_free;
   logic [L2_WAY_W-1:0] l2_hit_way, l2_free_way;
   logic [L1_WAY_W-1:0] pick1, iter1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign q_hold    = (state_ff == S_CLEAR);

   // victim block number and the L1 set it maps to
   assign vblk    = {vtag_ff, item_ff.l2_set};
   assign inv_row = {item_ff.core, vblk[L1_SET_W-1:0]};
   assign pick1   = pick_ff[L1_WAY_W-1:0];
   assign iter1   = iter_ff[L1_WAY_W-1:0];

   // L1 way search on the registered read row, lowest way first
   always_comb begin
      l1_rd       = (state_ff == S_INV_I || (state_ff == S_L1_LOOK && item_ff.insn))
                    ? l1i_q : l1d_q;
      l1_cmp_tag  = (state_ff == S_L1_LOOK) ? item_ff.l1_tag : vblk[BLK_W-1:L1_SET_W];
      l1_hit      = 1'b0;
      l1_free     = 1'b0;
      l1_hit_way  = '0;
      l1_free_way = '0;
      for (int w = L1_WAYS - 1; w >= 0; w--) begin
         if (l1_rd.vld[w] && l1_rd.tag[w] == l1_cmp_tag) begin
            l1_hit     = 1'b1;
            l1_hit_way = L1_WAY_W'(w);
         end
         if (!l1_rd.vld[w]) begin
            l1_free     = 1'b1;
            l1_free_way = L1_WAY_W'(w);
         end
      end
   end

   // L2 way search
   always_comb begin
      l2_hit      = 1'b0;
      l2_free     = 1'b0;
      l2_hit_way  = '0;
      l2_free_way = '0;
      for (int w = L2_WAYS - 1; w >= 0; w--) begin
         if (l2_q.vld[w] && l2_q.tag[w] == item_ff.l2_tag) begin
            l2_hit     = 1'b1;
            l2_hit_way = L2_WAY_W'(w);
         end
         if (!l2_q.vld[w]) begin
            l2_free     = 1'b1;
            l2_free_way = L2_WAY_W'(w);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      l1_row_in    = l1_row_ff;
      l2_row_in    = l2_row_ff;
      pick_in      = pick_ff;
      iter_in      = iter_ff;
      vtag_in      = vtag_ff;
      clr_in       = clr_ff;
      q_pop        = 1'b0;
      l1_raddr     = {item_ff.core, item_ff.l1_set};
      l2_raddr     = {item_ff.core, item_ff.l2_set};
      l1_waddr     = {item_ff.core, item_ff.l1_set};
      l2_waddr     = {item_ff.core, item_ff.l2_set};
      l1d_we       = 1'b0;
      l1i_we       = 1'b0;
      l2_we        = 1'b0;
      l1_wdata     = l1_row_ff;
      l2_wdata     = l2_row_ff;
      unique case (state_ff)
         S_CLEAR: begin
            l1_waddr = clr_ff[L1_ROW_W-1:0];
            l1_wdata = '0;
            l1d_we   = (clr_ff < L2_ROW_W'(L1_ROWS));
            l1i_we   = (clr_ff < L2_ROW_W'(L1_ROWS));
            l2_waddr = clr_ff;
            l2_wdata = '0;
            l2_we    = 1'b1;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == L2_ROW_W'(L2_ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            l1_raddr = {q_item.core, q_item.l1_set};
            if (q_ctl.valid) begin
               q_pop           = 1'b1;
               item_in         = q_item;
               res_in          = '0;
               res_in.was_user = q_item.user;
               state_in        = S_L1_LOOK;
            end
         end
         S_L1_LOOK: begin
            l1_row_in     = l1_rd;
            res_in.l1_hit = l1_hit;
            if (l1_hit) begin
               pick_in  = L2_WAY_W'(l1_hit_way);
               state_in = S_L1_WR;
            end else if (l1_free) begin
               pick_in  = L2_WAY_W'(l1_free_way);
               state_in = S_L1_WR;
            end else begin
               pick_in  = '0;
               iter_in  = L2_WAY_W'(1);
               state_in = (L1_WAYS > 1) ? S_L1_MIN : S_L1_WR;
            end
         end
         S_L1_MIN: begin
            if (l1_row_ff.stamp[iter1] < l1_row_ff.stamp[pick1]) begin
               pick_in = iter_ff;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == L2_WAY_W'(L1_WAYS - 1)) begin
               state_in = S_L1_WR;
            end
         end
         S_L1_WR: begin
            l1_wdata.stamp[pick1] = l1_row_ff.clk;
            l1_wdata.clk          = l1_row_ff.clk + 1'b1;
            l1_wdata.tag[pick1]   = item_ff.l1_tag;
            l1_wdata.vld[pick1]   = 1'b1;
            l1d_we                = !item_ff.insn;
            l1i_we                = item_ff.insn;
            if (res_ff.l1_hit) begin
               state_in = S_DONE;
            end else begin
               res_in.l2_probed = 1'b1;
               state_in         = S_L2_LOOK;
            end
         end
         S_L2_LOOK: begin
            l2_row_in     = l2_q;
            res_in.l2_hit = l2_hit;
            if (l2_hit) begin
               pick_in  = l2_hit_way;
               state_in = S_L2_WR;
            end else if (l2_free) begin
               pick_in  = l2_free_way;
               state_in = S_L2_WR;
            end else begin
               pick_in  = '0;
               iter_in  = L2_WAY_W'(1);
               state_in = (L2_WAYS > 1) ? S_L2_MIN : S_L2_WR;
            end
         end
         S_L2_MIN: begin
            if (l2_row_ff.stamp[iter_ff] < l2_row_ff.stamp[pick_ff]) begin
               pick_in = iter_ff;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == L2_WAY_W'(L2_WAYS - 1)) begin
               state_in = S_L2_WR;
            end
         end
         S_L2_WR: begin
            l2_wdata.stamp[pick_ff] = l2_row_ff.clk;
            l2_wdata.clk            = l2_row_ff.clk + 1'b1;
            l2_wdata.tag[pick_ff]   = item_ff.l2_tag;
            l2_wdata.vld[pick_ff]   = 1'b1;
            l2_we                   = 1'b1;
            // a full set on a miss displaces a valid block
            if (!res_ff.l2_hit && (&l2_row_ff.vld)) begin
               vtag_in               = l2_row_ff.tag[pick_ff];
               res_in.victim_valid   = 1'b1;
               res_in.victim_address = {l2_row_ff.tag[pick_ff], item_ff.l2_set,
                                        OFS_W'(0)};
               state_in              = S_INV_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_INV_RD: begin
            l1_raddr = inv_row;
            state_in = S_INV_D;
         end
         S_INV_D: begin
            l1_raddr = inv_row;
            l1_waddr = inv_row;
            l1_wdata = l1d_q;
            l1_wdata.vld[l1_hit_way] = 1'b0;
            l1d_we   = l1_hit;
            res_in.data_l1_invalidated = l1_hit;
            state_in = S_INV_I;
         end
         S_INV_I: begin
            l1_raddr = inv_row;
            l1_waddr = inv_row;
            l1_wdata = l1i_q;
            l1_wdata.vld[l1_hit_way] = 1'b0;
            l1i_we   = l1_hit;
            res_in.insn_l1_invalidated = l1_hit;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
      l1_row_ff <= l1_row_in;
      l2_row_ff <= l2_row_in;
      pick_ff   <= pick_in;
      iter_ff   <= iter_in;
      vtag_ff   <= vtag_in;
   end

   // L1 data array
   always_ff @(posedge clock) begin
      if (l1d_we) begin
         l1d_mem[l1_waddr] <= l1_wdata;
      end
      l1d_q <= l1d_mem[l1_raddr];
   end

   // L1 instruction array
   always_ff @(posedge clock) begin
      if (l1i_we) begin
         l1i_mem[l1_waddr] <= l1_wdata;
      end
      l1i_q <= l1i_mem[l1_raddr];
   end

   // L2 array
   always_ff @(posedge clock) begin
      if (l2_we) begin
         l2_mem[l2_waddr] <= l2_wdata;
      end
      l2_q <= l2_mem[l2_raddr];
   end

endmodule

FILE: rtl/inclusive_two_level_cache_model_unit.sv
// top level of the inclusive two-level cache model
// Tag-only model of per-core L1D/L1I over a unified L2, 4 cores, LRU by stamps.
// Request channel (req_*): one access per beat: action (0 data, 1 fetch), core,
// byte address and user flag. Accesses are decoded and held in a two-entry
// queue, so the requester keeps going while the back end works.
// Result channel (rsp_*): exactly one beat per access, in order: L1 hit, L2
// probe and hit, L2 victim address and which L1s dropped the victim.
// Steps per access: the L1 lookup and the L1 write; for a full L1 set an LRU
// scan in between (one way per cycle); on an L1 miss the L2 lookup and the L2
// write, with an LRU scan of a full L2 set in between; for a victim, one read
// and then one invalidation step per L1.
// Reset: synchronous, active high; then a clearing pass walks the 8192 rows of
// the L2 set array (and the 128 L1 sets) while req_ready stays low.
// A stalled result waits in the output register; the back end holds the
// next finished result until it drains, and the queue keeps taking requests
// until it is full.
module inclusive_two_level_cache_model_unit import itlc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [1:0]        req_core,
   input  logic [ADDR_W-1:0] req_address,
   input  logic              req_user_mode,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_l1_hit,
   output logic              rsp_l2_probed,
   output logic              rsp_l2_hit,
   output logic              rsp_victim_valid,
   output logic [ADDR_W-1:0] rsp_victim_address,
   output logic              rsp_data_l1_invalidated,
   output logic              rsp_insn_l1_invalidated,
   output logic              rsp_was_user
);

   queue_ctl_type q_ctl;
   item_type      q_item;
   logic          q_pop;
   logic          q_hold;
   result_type    rsp_data;

   itlc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_core      (req_core),
      .req_address   (req_address),
      .req_user_mode (req_user_mode),
      .q_ctl         (q_ctl),
      .q_hold        (q_hold),
      .q_pop         (q_pop),
      .q_item        (q_item)
   );

   itlc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_ctl     (q_ctl),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .q_hold    (q_hold),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // result fields
   assign rsp_l1_hit              = rsp_data.l1_hit;
   assign rsp_l2_probed           = rsp_data.l2_probed;
   assign rsp_l2_hit              = rsp_data.l2_hit;
   assign rsp_victim_valid        = rsp_data.victim_valid;
   assign rsp_victim_address      = rsp_data.victim_address;
   assign rsp_data_l1_invalidated = rsp_data.data_l1_invalidated;
   assign rsp_insn_l1_invalidated = rsp_data.insn_l1_invalidated;
   assign rsp_was_user            = rsp_data.was_user;

endmodule

FILE: rtl/itlc_checker.sv
// port-level checker for the cache model, bound to the top level
module itlc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_l1_hit,
   input logic        rsp_l2_probed,
   input logic        rsp_l2_hit,
   input logic        rsp_victim_valid,
   input logic [63:0] rsp_victim_address,
   input logic        rsp_data_l1_invalidated,
   input logic        rsp_insn_l1_invalidated
);

   // a stalled result beat stays valid and keeps its victim address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_victim_address))
      else $error("stalled result changed");

   // no requests taken right after reset while the arrays are cleared
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // an L1 hit never reaches L2, a miss always does
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_l1_hit != rsp_l2_probed) && (rsp_l1_hit ? !rsp_l2_hit : 1'b1))
      else $error("inconsistent L1/L2 flags");

   // back-invalidation only follows a real victim from an L2 miss
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data_l1_invalidated || rsp_insn_l1_invalidated)
      |-> rsp_victim_valid && rsp_l2_probed && !rsp_l2_hit)
      else $error("invalidation without victim");

   // victim address is zero without a victim and block aligned with one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_victim_valid ? (rsp_victim_address[5:0] == 6'd0)
                                      : (rsp_victim_address == 64'd0)))
      else $error("bad victim address");

endmodule

bind inclusive_two_level_cache_model_unit itlc_checker u_itlc_checker (.*);

FILE: tb/tb_top.sv
// self-checking testbench of the inclusive two-level cache model
`timescale 1ns / 100ps

module tb_top;
   import itlc_pkg::*;

   // entry counts of the predictor arrays
   localparam int PL1_ENTRIES = NUM_CORES * L1_SETS * L1_WAYS;
   localparam int PL2_ENTRIES = NUM_CORES * L2_SETS * L2_WAYS;

   // idling modes
   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_action = 1'b0;
   logic [1:0]        req_core = '0;
   logic [ADDR_W-1:0] req_address = '0;
   logic              req_user_mode = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_l1_hit;
   logic              rsp_l2_probed;
   logic              rsp_l2_hit;
   logic              rsp_victim_valid;
   logic [ADDR_W-1:0] rsp_victim_address;
   logic              rsp_data_l1_invalidated;
   logic              rsp_insn_l1_invalidated;
   logic              rsp_was_user;

   // predictor state: tags, valid bits and stamps of every cache
   logic [L1_TAG_W-1:0] dc_tag [PL1_ENTRIES];
   logic                dc_vld [PL1_ENTRIES];
   logic [STAMP_W-1:0]  dc_stamp [PL1_ENTRIES];
   logic [STAMP_W-1:0]  dc_clk [L1_ROWS];
   logic [L1_TAG_W-1:0] ic_tag [PL1_ENTRIES];
   logic                ic_vld [PL1_ENTRIES];
   logic [STAMP_W-1:0]  ic_stamp [PL1_ENTRIES];
   logic [STAMP_W-1:0]  ic_clk [L1_ROWS];
   logic [L2_TAG_W-1:0] uc_tag [PL2_ENTRIES];
   logic                uc_vld [PL2_ENTRIES];
   logic [STAMP_W-1:0]  uc_stamp [PL2_ENTRIES];
   logic [STAMP_W-1:0]  uc_clk [L2_ROWS];

   result_type    pending_results[$];
   idle_mode_type idle_mode = IDLE_NONE;
   int            fail_count = 0;
   bit            recv_hold = 1'b0;

   inclusive_two_level_cache_model_unit u_dut (.*);

   // clock
   always #5 clock = ~clock;

   // run limit
   initial begin
      #60ms;
      $display("FAILURE");
      $finish;
   end

   // L1 lookup and fill, true on hit
   function automatic bit l1_access(bit insn, int row, logic [L1_TAG_W-1:0] tg);
      int base, pick, w;
      bit found;
      base = row * L1_WAYS;
      pick = 0;
      found = 1'b0;
      for (w = 0; w < L1_WAYS; w++) begin
         if ((insn ? ic_vld[base+w] : dc_vld[base+w]) &&
             (insn ? ic_tag[base+w] : dc_tag[base+w]) == tg) begin
            if (insn) begin
               ic_stamp[base+w] = ic_clk[row]; ic_clk[row]++;
            end else begin
               dc_stamp[base+w] = dc_clk[row]; dc_clk[row]++;
            end
            return 1'b1;
         end
      end
      for (w = 0; w < L1_WAYS && !found; w++)
         if (!(insn ? ic_vld[base+w] : dc_vld[base+w])) begin
            pick = w; found = 1'b1;
         end
      if (!found)
         for (w = 1; w < L1_WAYS; w++)
            if ((insn ? ic_stamp[base+w] : dc_stamp[base+w]) <
                (insn ? ic_stamp[base+pick] : dc_stamp[base+pick]))
               pick = w;
      if (insn) begin
         ic_stamp[base+pick] = ic_clk[row]; ic_clk[row]++;
         ic_tag[base+pick] = tg; ic_vld[base+pick] = 1'b1;
      end else begin
         dc_stamp[base+pick] = dc_clk[row]; dc_clk[row]++;
         dc_tag[base+pick] = tg; dc_vld[base+pick] = 1'b1;
      end
      return 1'b0;
   endfunction

   // drop a victim block from one L1, true when it was present
   function automatic bit l1_drop(bit insn, int row, logic [L1_TAG_W-1:0] tg);
      int base, w;
      base = row * L1_WAYS;
      for (w = 0; w < L1_WAYS; w++)
         if ((insn ? ic_vld[base+w] : dc_vld[base+w]) &&
             (insn ? ic_tag[base+w] : dc_tag[base+w]) == tg) begin
            if (insn) ic_vld[base+w] = 1'b0;
            else dc_vld[base+w] = 1'b0;
            return 1'b1;
         end
      return 1'b0;
   endfunction

   // full access of the hierarchy, one result
   function automatic result_type cache_access(bit insn, logic [1:0] cr,
                                               logic [ADDR_W-1:0] addr, bit usr);
      result_type r;
      logic [BLK_W-1:0]    blk, vblk;
      logic [L2_SET_W-1:0] s2;
      logic [L2_TAG_W-1:0] old;
      int row2, base, w, pick;
      bit hit, found;
      r = '0;
      r.was_user = usr;
      blk = addr[ADDR_W-1:OFS_W];
      r.l1_hit = l1_access(insn, int'(cr) * L1_SETS + int'(blk[L1_SET_W-1:0]),
                           blk[BLK_W-1:L1_SET_W]);
      if (r.l1_hit) return r;
      r.l2_probed = 1'b1;
      s2 = blk[L2_SET_W-1:0];
      row2 = int'(cr) * L2_SETS + int'(s2);
      base = row2 * L2_WAYS;
      hit = 1'b0;
      for (w = 0; w < L2_WAYS && !hit; w++)
         if (uc_vld[base+w] && uc_tag[base+w] == blk[BLK_W-1:L2_SET_W]) begin
            uc_stamp[base+w] = uc_clk[row2]; uc_clk[row2]++;
            hit = 1'b1;
         end
      r.l2_hit = hit;
      if (hit) return r;
      pick = 0;
      found = 1'b0;
      for (w = 0; w < L2_WAYS && !found; w++)
         if (!uc_vld[base+w]) begin
            pick = w; found = 1'b1;
         end
      if (!found) begin
         for (w = 1; w < L2_WAYS; w++)
            if (uc_stamp[base+w] < uc_stamp[base+pick]) pick = w;
         old = uc_tag[base+pick];
         vblk = {old, s2};
         r.victim_valid = 1'b1;
         r.victim_address = {vblk, {OFS_W{1'b0}}};
         r.data_l1_invalidated = l1_drop(1'b0,
            int'(cr) * L1_SETS + int'(vblk[L1_SET_W-1:0]), vblk[BLK_W-1:L1_SET_W]);
         r.insn_l1_invalidated = l1_drop(1'b1,
            int'(cr) * L1_SETS + int'(vblk[L1_SET_W-1:0]), vblk[BLK_W-1:L1_SET_W]);
      end
      uc_stamp[base+pick] = uc_clk[row2]; uc_clk[row2]++;
      uc_tag[base+pick] = blk[BLK_W-1:L2_SET_W];
      uc_vld[base+pick] = 1'b1;
      return r;
   endfunction

   // send one access beat and record its expected result
   task automatic send_access(bit insn, logic [1:0] cr, logic [ADDR_W-1:0] addr, bit usr);
      if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
         while ($urandom_range(99) < (idle_mode == IDLE_SEND ? 53 : 30)) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_action <= insn;
      req_core <= cr;
      req_address <= addr;
      req_user_mode <= usr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(cache_access(insn, cr, addr, usr));
   endtask

   // address built from block fields: L2 tag, L2 set, byte offset
   function automatic logic [ADDR_W-1:0] block_addr(logic [L2_TAG_W-1:0] tg,
                                                    logic [L2_SET_W-1:0] s,
                                                    logic [OFS_W-1:0] ofs);
      return {tg, s, ofs};
   endfunction

   // receiver stall
   always @(posedge clock) begin
      if (recv_hold)
         rsp_ready <= 1'b0;
      else case (idle_mode)
         IDLE_RECV: rsp_ready <= ($urandom_range(99) >= 53);
         IDLE_BOTH: rsp_ready <= ($urandom_range(99) >= 30);
         default:   rsp_ready <= 1'b1;
      endcase
   end

   // result checker
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no access outstanding");
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_l1_hit !== e.l1_hit) begin
               $error("l1_hit exp %0h got %0h", e.l1_hit, rsp_l1_hit); fail_count++;
            end
            if (rsp_l2_probed !== e.l2_probed) begin
               $error("l2_probed exp %0h got %0h", e.l2_probed, rsp_l2_probed);
               fail_count++;
            end
            if (rsp_l2_hit !== e.l2_hit) begin
               $error("l2_hit exp %0h got %0h", e.l2_hit, rsp_l2_hit); fail_count++;
            end
            if (rsp_victim_valid !== e.victim_valid) begin
               $error("victim_valid exp %0h got %0h", e.victim_valid, rsp_victim_valid);
               fail_count++;
            end
            if (rsp_victim_address !== e.victim_address) begin
               $error("victim_address exp %0h got %0h", e.victim_address,
                      rsp_victim_address);
               fail_count++;
            end
            if (rsp_data_l1_invalidated !== e.data_l1_invalidated) begin
               $error("data_l1_invalidated exp %0h got %0h", e.data_l1_invalidated,
                      rsp_data_l1_invalidated);
               fail_count++;
            end
            if (rsp_insn_l1_invalidated !== e.insn_l1_invalidated) begin
               $error("insn_l1_invalidated exp %0h got %0h", e.insn_l1_invalidated,
                      rsp_insn_l1_invalidated);
               fail_count++;
            end
            if (rsp_was_user !== e.was_user) begin
               $error("was_user exp %0h got %0h", e.was_user, rsp_was_user);
               fail_count++;
            end
         end
      end
   end

   // directed: field extremes, hits, L2 hits and an L2 eviction
   task automatic test_directed();
      int k;
      send_access(1'b0, 2'd0, '0, 1'b0);
      send_access(1'b0, 2'd0, '0, 1'b1);
      send_access(1'b1, 2'd3, '1, 1'b1);
      send_access(1'b1, 2'd3, '1, 1'b0);
      send_access(1'b1, 2'd0, '0, 1'b0);
      // fill one L2 set past its ways; the victim is then in neither L1
      for (k = 0; k <= L2_WAYS; k++)
         send_access(k[0], 2'd1, block_addr(L2_TAG_W'(k), 11'h5, 6'h3f), k[1]);
      // data access to a block held only in L1I and L2 gives an L2 hit
      send_access(1'b0, 2'd1, block_addr(L2_TAG_W'(1), 11'h5, OFS_W'(0)), 1'b0);
      send_access(1'b0, 2'd2, block_addr('1, '1, OFS_W'(0)), 1'b1);
   endtask

   // random: hot sets force L1 and L2 conflicts
   task automatic test_random(int n);
      int k;
      logic [ADDR_W-1:0] a;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(3))
            0: a = {$urandom, $urandom};
            1: a = block_addr(L2_TAG_W'({$urandom, $urandom}), L2_SET_W'($urandom),
                              OFS_W'($urandom));
            default: a = block_addr(L2_TAG_W'($urandom_range(24)) |
                                    ($urandom_range(7) == 0 ?
                                     L2_TAG_W'({$urandom, 15'h0}) : L2_TAG_W'(0)),
                                    {1'($urandom_range(1)), 8'h0, 2'($urandom_range(3))},
                                    OFS_W'($urandom));
         endcase
         send_access(1'($urandom_range(1)), 2'($urandom_range(3)), a,
                     1'($urandom_range(1)));
      end
   endtask

   // long receiver hold-off while the sender keeps offering
   task automatic test_backpressure();
      int k;
      recv_hold = 1'b1;
      fork
         test_random(12);
         begin
            for (k = 0; k < 300; k++) @(posedge clock);
            recv_hold = 1'b0;
         end
      join
   endtask

   initial begin
      int k;
      for (k = 0; k < PL1_ENTRIES; k++) begin
         dc_vld[k] = 0; dc_stamp[k] = 0; dc_tag[k] = 0;
         ic_vld[k] = 0; ic_stamp[k] = 0; ic_tag[k] = 0;
      end
      for (k = 0; k < L1_ROWS; k++) begin
         dc_clk[k] = 0; ic_clk[k] = 0;
      end
      for (k = 0; k < PL2_ENTRIES; k++) begin
         uc_vld[k] = 0; uc_stamp[k] = 0; uc_tag[k] = 0;
      end
      for (k = 0; k < L2_ROWS; k++) uc_clk[k] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      idle_mode = IDLE_NONE;  test_random(430);
      idle_mode = IDLE_SEND;  test_random(430);
      idle_mode = IDLE_RECV;  test_random(430);
      idle_mode = IDLE_BOTH;  test_random(430);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/itlc_pkg.sv
rtl/itlc_front.sv
rtl/itlc_back.sv
rtl/inclusive_two_level_cache_model_unit.sv
rtl/itlc_checker.sv
tb/tb_top.sv
